>>> hw/rtl/utf8dec_pkg.sv
// shared types, constants and byte classification for the utf-8 stream decoder
package utf8dec_pkg;

  localparam int CP_W   = 21;
  localparam int USED_W = 3;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;

  typedef enum logic [2:0] {
    CLS_CONT  = 3'd0,
    CLS_LEAD1 = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_LEAD4 = 3'd4,
    CLS_BAD   = 3'd5
  } byte_class_t;

  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic              rep;
    logic [USED_W-1:0] used;
  } result_t;

  // one queue entry: results of one transaction, one or two
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_port_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    if (b[7:6] == 2'b10)         c = CLS_CONT;
    else if (!b[7])              c = CLS_LEAD1;
    else if (b[7:5] == 3'b110)   c = CLS_LEAD2;
    else if (b[7:4] == 4'b1110)  c = CLS_LEAD3;
    else if (b[7:3] == 5'b11110) c = CLS_LEAD4;
    else                         c = CLS_BAD;
    return c;
  endfunction

  function automatic logic [CP_W-1:0] len_min(input logic [USED_W-1:0] len);
    logic [CP_W-1:0] v;
    unique case (len)
      3'd2:    v = 21'h000080;
      3'd3:    v = 21'h000800;
      3'd4:    v = 21'h010000;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [CP_W-1:0] len_max(input logic [USED_W-1:0] len);
    logic [CP_W-1:0] v;
    unique case (len)
      3'd1:    v = 21'h00007F;
      3'd2:    v = 21'h0007FF;
      3'd3:    v = 21'h00FFFF;
      3'd4:    v = CP_MAX;
      default: v = CP_MAX;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/utf8dec_front.sv
// front end: byte classification, sequence state and result building
module utf8dec_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          byte_in,
  input  logic                end_of_text,
  output utf8dec_pkg::q_port_t push
);
  import utf8dec_pkg::*;

  logic [USED_W-1:0] exp_len_r, exp_len_nxt;
  logic [USED_W-1:0] seen_r, seen_nxt;
  logic [CP_W-1:0]   acc_r, acc_nxt;

  byte_class_t       cls;
  logic              pending;
  logic [CP_W-1:0]   acc_cat;
  logic [USED_W-1:0] seen_inc;
  logic [CP_W-1:0]   payload;
  logic              bad;
  logic              have;
  logic              two;
  result_t           r0, r1, rb;

  assign cls      = classify(byte_in);
  assign pending  = (exp_len_r != '0);
  assign acc_cat  = {acc_r[CP_W-7:0], byte_in[5:0]};
  assign seen_inc = seen_r + 3'd1;
  assign bad      = (acc_cat < len_min(exp_len_r)) || (acc_cat > len_max(exp_len_r)) ||
                    ((acc_cat >= SURR_LO) && (acc_cat <= SURR_HI));

  always_comb begin
    unique case (cls)
      CLS_LEAD2: payload = {16'd0, byte_in[4:0]};
      CLS_LEAD3: payload = {17'd0, byte_in[3:0]};
      CLS_LEAD4: payload = {18'd0, byte_in[2:0]};
      default:   payload = '0;
    endcase
  end

  always_comb begin
    exp_len_nxt = exp_len_r;
    seen_nxt    = seen_r;
    acc_nxt     = acc_r;
    have        = 1'b0;
    two         = 1'b0;
    r0          = '{cp: CP_REPL, rep: 1'b1, used: 3'd1};
    r1          = '{cp: CP_REPL, rep: 1'b1, used: 3'd1};
    rb          = '{cp: CP_REPL, rep: 1'b1, used: 3'd1};
    if (pending && cls == CLS_CONT) begin
      acc_nxt  = acc_cat;
      seen_nxt = seen_inc;
      if (seen_inc >= exp_len_r) begin
        have        = 1'b1;
        r0.cp       = bad ? CP_REPL : acc_cat;
        r0.rep      = bad;
        r0.used     = exp_len_r;
        exp_len_nxt = '0;
        seen_nxt    = '0;
        acc_nxt     = '0;
      end
    end else begin
      // truncated sequence reports first, then this byte restarts decoding
      if (pending) begin
        have        = 1'b1;
        r0.used     = seen_r;
        exp_len_nxt = '0;
        seen_nxt    = '0;
        acc_nxt     = '0;
      end
      case (cls) inside
        CLS_CONT, CLS_BAD, CLS_LEAD1: begin
          if (cls == CLS_LEAD1) begin
            rb.cp  = {13'd0, byte_in};
            rb.rep = 1'b0;
          end
          if (pending) begin
            two = 1'b1;
            r1  = rb;
          end else begin
            have = 1'b1;
            r0   = rb;
          end
        end
        default: begin
          exp_len_nxt = cls[USED_W-1:0];
          seen_nxt    = 3'd1;
          acc_nxt     = payload;
        end
      endcase
    end
    if (end_of_text) begin
      exp_len_nxt = '0;
      seen_nxt    = '0;
      acc_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= '0;
      seen_r    <= '0;
      acc_r     <= '0;
    end else if (accept) begin
      exp_len_r <= exp_len_nxt;
      seen_r    <= seen_nxt;
      acc_r     <= acc_nxt;
    end
  end

  assign push.valid     = accept && have;
  assign push.entry.two = two;
  assign push.entry.r0  = r0;
  assign push.entry.r1  = r1;

endmodule

>>> hw/rtl/utf8dec_queue.sv
// small fifo of decoded entries between front and back end
module utf8dec_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utf8dec_pkg::q_port_t push,
  input  logic                 pop,
  output utf8dec_pkg::q_port_t head,
  output logic                 full
);
  import utf8dec_pkg::*;

  entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !do_pop)      count_nxt = count_r + 1'b1;
    else if (!push.valid && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)     rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/utf8dec_back.sv
// back end: output register that walks the one or two results of each entry
module utf8dec_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  utf8dec_pkg::q_port_t       head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [utf8dec_pkg::CP_W-1:0]   out_code_point,
  output logic                       out_replaced,
  output logic [utf8dec_pkg::USED_W-1:0] out_bytes_used,
  output logic                       out_last_of_run
);
  import utf8dec_pkg::*;

  entry_t  cur_r;
  logic    cur_valid_r;
  logic    sub_r;
  logic    taken;
  logic    done;
  logic    load;
  result_t sel;

  assign taken = cur_valid_r && out_ready;
  assign done  = taken && (sub_r || !cur_r.two);
  assign load  = !cur_valid_r || done;
  assign pop   = load && head.valid;
  assign sel   = sub_r ? cur_r.r1 : cur_r.r0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else if (load) begin
      cur_valid_r <= head.valid;
      sub_r       <= 1'b0;
    end else if (taken) begin
      sub_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur_r <= head.entry;
  end

  assign out_valid       = cur_valid_r;
  assign out_code_point  = sel.cp;
  assign out_replaced    = sel.rep;
  assign out_bytes_used  = sel.used;
  assign out_last_of_run = sub_r || !cur_r.two;

endmodule

>>> hw/rtl/utf8_stream_decoder.sv
// top level of the utf-8 stream decoder
//
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_ready   | in_byte_in, in_end_of_text
// out_    | output    | out_valid / out_ready | out_code_point, out_replaced,
//         |           |                       | out_bytes_used, out_last_of_run
//
// one byte per cycle while in_ready is high; the front end decodes it in the
// cycle it is taken; a result passes through the queue and the output register;
// a byte that yields two results holds the output register until both are taken
// in_ready drops only while the four-entry queue is full
// reset is synchronous; it clears the sequence state, queue and output valid
module utf8_stream_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte_in,
  input  logic                           in_end_of_text,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [utf8dec_pkg::CP_W-1:0]   out_code_point,
  output logic                           out_replaced,
  output logic [utf8dec_pkg::USED_W-1:0] out_bytes_used,
  output logic                           out_last_of_run
);
  import utf8dec_pkg::*;

  q_port_t push;
  q_port_t head;
  logic    full;
  logic    pop;

  assign in_ready = !full;

  utf8dec_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_valid && in_ready),
    .byte_in     (in_byte_in),
    .end_of_text (in_end_of_text),
    .push        (push)
  );

  utf8dec_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (full)
  );

  utf8dec_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_replaced    (out_replaced),
    .out_bytes_used  (out_bytes_used),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> hw/rtl/utf8dec_checker.sv
// port-level checks for the utf-8 stream decoder, bound to the top level
module utf8dec_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [7:0]                     in_byte_in,
  input logic                           in_end_of_text,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [utf8dec_pkg::CP_W-1:0]   out_code_point,
  input logic                           out_replaced,
  input logic [utf8dec_pkg::USED_W-1:0] out_bytes_used,
  input logic                           out_last_of_run
);
  import utf8dec_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point) &&
      $stable(out_replaced) && $stable(out_bytes_used) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replaced |-> out_code_point == CP_REPL)
    else $error("replaced result without replacement character");

  a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_replaced |-> out_code_point <= CP_MAX &&
      !(out_code_point >= SURR_LO && out_code_point <= SURR_HI))
    else $error("decoded value is not a scalar value");

  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bytes_used != 3'd0 && out_bytes_used <= 3'd4)
    else $error("byte count out of range");

endmodule

bind utf8_stream_decoder utf8dec_checker u_chk (.*);
